// ===== hdl/pfgm_pkg.sv =====
// Package for the periodic frame gap monitor.
// Field widths, register indexes, reset values and beat records.
// No dependencies; every other file takes names from here by scope.
package pfgm_pkg;

	// Port field widths
	localparam int TS_W  = 48;
	localparam int ID_W  = 11;
	localparam int LEN_W = 4;
	localparam int PAY_W = 64;
	localparam int CNT_W = 32;
	localparam int CFG_W = 48;
	localparam int IDX_W = 4;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_WATCHED_ID = 4'd0;
	localparam logic [IDX_W-1:0] REG_STATUS_ID  = 4'd1;
	localparam logic [IDX_W-1:0] REG_GAP_THR    = 4'd2;
	localparam logic [IDX_W-1:0] REG_RUN_GAP    = 4'd3;

	// Register reset values
	localparam logic [ID_W-1:0]  WATCHED_ID_RST = 11'h07A;
	localparam logic [ID_W-1:0]  STATUS_ID_RST  = 11'h601;
	localparam logic [CFG_W-1:0] GAP_THR_RST    = 48'd50000;
	localparam logic [CFG_W-1:0] RUN_GAP_RST    = 48'd650000;

	// Status frame decoding
	localparam logic [LEN_W-1:0] LEN_FULL      = 4'd8;
	localparam logic [7:0]       PHASE_CODE_LO = 8'd2;
	localparam logic [7:0]       PHASE_CODE_HI = 8'd3;

	// One received frame
	typedef struct packed {
		logic [TS_W-1:0]  timestamp_us;
		logic [ID_W-1:0]  frame_id;
		logic [LEN_W-1:0] length_code;
		logic [PAY_W-1:0] payload;
		logic             armed;
	} frame_t;

	// One result beat
	typedef struct packed {
		logic             silence_event;
		logic             recovery_event;
		logic [TS_W-1:0]  event_gap_us;
		logic [CNT_W-1:0] armed_frames;
		logic [CNT_W-1:0] silence_count;
		logic [CNT_W-1:0] recoveries_out;
		logic [TS_W-1:0]  longest_gap_out;
		logic [TS_W-1:0]  period_min_out;
		logic [TS_W-1:0]  period_max_out;
		logic [TS_W-1:0]  period_sum_out;
		logic [CNT_W-1:0] closed_runs;
		logic [TS_W-1:0]  run_time_total;
	} result_t;

endpackage

// ===== hdl/pfgm_channels.sv =====
// Valid/ready channel interfaces of the periodic frame gap monitor.
// Frame channel in, result channel out. Depends on pfgm_pkg.
interface pfgm_frame_if;
	logic                        valid;
	logic                        ready;
	logic [pfgm_pkg::TS_W-1:0]   timestamp_us;
	logic [pfgm_pkg::ID_W-1:0]   frame_id;
	logic [pfgm_pkg::LEN_W-1:0]  length_code;
	logic [pfgm_pkg::PAY_W-1:0]  payload;
	logic                        armed;

	modport source(output valid, timestamp_us, frame_id, length_code, payload, armed,
		input ready);
	modport sink(input valid, timestamp_us, frame_id, length_code, payload, armed,
		output ready);
endinterface

interface pfgm_result_if;
	logic                        valid;
	logic                        ready;
	logic                        silence_event;
	logic                        recovery_event;
	logic [pfgm_pkg::TS_W-1:0]   event_gap_us;
	logic [pfgm_pkg::CNT_W-1:0]  armed_frames;
	logic [pfgm_pkg::CNT_W-1:0]  silence_count;
	logic [pfgm_pkg::CNT_W-1:0]  recoveries_out;
	logic [pfgm_pkg::TS_W-1:0]   longest_gap_out;
	logic [pfgm_pkg::TS_W-1:0]   period_min_out;
	logic [pfgm_pkg::TS_W-1:0]   period_max_out;
	logic [pfgm_pkg::TS_W-1:0]   period_sum_out;
	logic [pfgm_pkg::CNT_W-1:0]  closed_runs;
	logic [pfgm_pkg::TS_W-1:0]   run_time_total;

	modport source(output valid, silence_event, recovery_event, event_gap_us,
		armed_frames, silence_count, recoveries_out, longest_gap_out, period_min_out,
		period_max_out, period_sum_out, closed_runs, run_time_total, input ready);
	modport sink(input valid, silence_event, recovery_event, event_gap_us,
		armed_frames, silence_count, recoveries_out, longest_gap_out, period_min_out,
		period_max_out, period_sum_out, closed_runs, run_time_total, output ready);
endinterface

// ===== hdl/periodic_frame_gap_monitor_top.sv =====
// Periodic frame gap monitor, top level.
// Depends on pfgm_pkg and the channel interfaces in pfgm_channels.sv.
//
// The monitor takes one timestamped frame per clock unless the result side stalls it, and
// returns one result beat per frame. A frame is captured in an input register; when it
// advances, the whole statistics update (gap check, run tracking, period and recovery
// accounting, phase flag) is done in one pass and written into the state registers
// together with the result register. The result register decouples the two sides: a new
// frame is taken while a result still waits, and the input stalls only when both registers
// are full. Counters and sums saturate; time differences wrap modulo 2^TIME_WIDTH.
// Configuration writes take effect on the next edge and are meant for an idle block;
// unknown indexes are ignored.
module periodic_frame_gap_monitor_top #(
	parameter int TIME_WIDTH  = 48,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [pfgm_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pfgm_pkg::CFG_W-1:0]     cfg_data,
	pfgm_frame_if.sink                     frames,
	pfgm_result_if.source                  results
);

	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	// Saturating adders
	function automatic logic [TIME_WIDTH-1:0] sat_t(input logic [TIME_WIDTH-1:0] a,
		input logic [TIME_WIDTH-1:0] b);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_c(input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
	endfunction

	// Internal widths to port widths
	function automatic logic [pfgm_pkg::TS_W-1:0] port_t(input logic [TIME_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[pfgm_pkg::TS_W-1:0];
	endfunction

	function automatic logic [pfgm_pkg::CNT_W-1:0] port_c(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[pfgm_pkg::CNT_W-1:0];
	endfunction

	// Configuration registers
	logic [pfgm_pkg::ID_W-1:0]  watched_id_q, status_id_q;
	logic [pfgm_pkg::CFG_W-1:0] gap_thr_q, run_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_id_q <= pfgm_pkg::WATCHED_ID_RST;
			status_id_q  <= pfgm_pkg::STATUS_ID_RST;
			gap_thr_q    <= pfgm_pkg::GAP_THR_RST;
			run_gap_q    <= pfgm_pkg::RUN_GAP_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				pfgm_pkg::REG_WATCHED_ID: watched_id_q <= cfg_data[pfgm_pkg::ID_W-1:0];
				pfgm_pkg::REG_STATUS_ID:  status_id_q  <= cfg_data[pfgm_pkg::ID_W-1:0];
				pfgm_pkg::REG_GAP_THR:    gap_thr_q    <= cfg_data;
				pfgm_pkg::REG_RUN_GAP:    run_gap_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	pfgm_pkg::frame_t  frame_s1;
	logic              valid_s1;
	pfgm_pkg::result_t res_s2, res_d;
	logic              valid_s2;
	logic              advance;

	assign advance      = valid_s1 && (!valid_s2 || results.ready);
	assign frames.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (frames.ready) valid_s1 <= frames.valid;
			if (advance) valid_s2 <= 1'b1;
			else if (results.ready) valid_s2 <= 1'b0;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (frames.valid && frames.ready) begin
			frame_s1.timestamp_us <= frames.timestamp_us;
			frame_s1.frame_id     <= frames.frame_id;
			frame_s1.length_code  <= frames.length_code;
			frame_s1.payload      <= frames.payload;
			frame_s1.armed        <= frames.armed;
		end
	end

	// Monitor state
	logic                   seen_q, missing_q, phase_q, run_active_q;
	logic [TIME_WIDTH-1:0]  last_seen_q, period_sum_q, period_min_q, period_max_q;
	logic [TIME_WIDTH-1:0]  longest_gap_q, recovery_sum_q, first_sil_q;
	logic [TIME_WIDTH-1:0]  run_start_time_q, run_last_time_q, run_time_sum_q;
	logic [COUNT_WIDTH-1:0] period_samples_q, long_gap_cnt_q, recoveries_q, total_frames_q;
	logic [COUNT_WIDTH-1:0] armed_frames_q, silence_q;
	logic [COUNT_WIDTH-1:0] run_start_frames_q, run_last_frames_q, run_frame_sum_q;
	logic [COUNT_WIDTH-1:0] run_total_q;

	logic                   seen_d, missing_d, phase_d, run_active_d;
	logic [TIME_WIDTH-1:0]  last_seen_d, period_sum_d, period_min_d, period_max_d;
	logic [TIME_WIDTH-1:0]  longest_gap_d, recovery_sum_d, first_sil_d;
	logic [TIME_WIDTH-1:0]  run_start_time_d, run_last_time_d, run_time_sum_d;
	logic [COUNT_WIDTH-1:0] period_samples_d, long_gap_cnt_d, recoveries_d, total_frames_d;
	logic [COUNT_WIDTH-1:0] armed_frames_d, silence_d;
	logic [COUNT_WIDTH-1:0] run_start_frames_d, run_last_frames_d, run_frame_sum_d;
	logic [COUNT_WIDTH-1:0] run_total_d;

	// Per-frame differences
	logic [63:0]            ts_wide;
	logic [TIME_WIDTH-1:0]  ts, since, run_span, run_dur;
	logic [COUNT_WIDTH-1:0] run_fdur;
	logic                   over_thr, run_broken, watched, sil, rec, missing_eff;
	logic                   run_open, phase_hit;

	assign ts_wide    = 64'(frame_s1.timestamp_us);
	assign ts         = ts_wide[TIME_WIDTH-1:0];
	assign since      = ts - last_seen_q;
	assign run_span   = ts - run_last_time_q;
	assign run_dur    = run_last_time_q - run_start_time_q;
	assign run_fdur   = run_last_frames_q - run_start_frames_q;
	assign over_thr   = 64'(since) > 64'(gap_thr_q);
	assign run_broken = 64'(run_span) > 64'(run_gap_q);
	assign watched    = frame_s1.frame_id == watched_id_q;

	// Status byte 4, bytes 5..6 and byte 7
	assign phase_hit = (frame_s1.payload[39:32] == pfgm_pkg::PHASE_CODE_LO)
		|| (frame_s1.payload[39:32] == pfgm_pkg::PHASE_CODE_HI)
		|| (frame_s1.payload[55:40] != '0) || (frame_s1.payload[63:56] != '0);

	// One-pass state update
	always_comb begin
		seen_d             = seen_q;
		missing_d          = missing_q;
		phase_d            = phase_q;
		run_active_d       = run_active_q;
		last_seen_d        = last_seen_q;
		period_sum_d       = period_sum_q;
		period_min_d       = period_min_q;
		period_max_d       = period_max_q;
		longest_gap_d      = longest_gap_q;
		recovery_sum_d     = recovery_sum_q;
		first_sil_d        = first_sil_q;
		run_start_time_d   = run_start_time_q;
		run_last_time_d    = run_last_time_q;
		run_time_sum_d     = run_time_sum_q;
		period_samples_d   = period_samples_q;
		long_gap_cnt_d     = long_gap_cnt_q;
		recoveries_d       = recoveries_q;
		total_frames_d     = total_frames_q;
		armed_frames_d     = armed_frames_q;
		silence_d          = silence_q;
		run_start_frames_d = run_start_frames_q;
		run_last_frames_d  = run_last_frames_q;
		run_frame_sum_d    = run_frame_sum_q;
		run_total_d        = run_total_q;
		run_open           = run_active_q;
		rec                = 1'b0;

		// silence window check, every frame
		sil = frame_s1.armed && seen_q && !missing_q && over_thr;
		if (sil) begin
			silence_d = sat_c(silence_q, CNT_ONE);
			if (silence_q == '0) first_sil_d = ts;
			if (phase_q) begin
				if (run_active_q && run_broken) begin
					run_time_sum_d  = sat_t(run_time_sum_q, run_dur);
					run_frame_sum_d = sat_c(run_frame_sum_q, run_fdur);
					run_total_d     = sat_c(run_total_q, CNT_ONE);
					run_open        = 1'b0;
				end
				if (!run_open) begin
					run_start_time_d   = ts;
					run_start_frames_d = armed_frames_q;
				end
				run_active_d      = 1'b1;
				run_last_time_d   = ts;
				run_last_frames_d = armed_frames_q;
			end
		end

		// longest gap: from a new silence window or an over-threshold watched interval
		if (frame_s1.armed && seen_q && over_thr && (!missing_q || watched)
			&& since > longest_gap_q) begin
			longest_gap_d = since;
		end

		missing_eff = missing_q || sil;
		if (watched) begin
			if (seen_q) begin
				period_sum_d     = sat_t(period_sum_q, since);
				period_samples_d = sat_c(period_samples_q, CNT_ONE);
				if (since < period_min_q) period_min_d = since;
				if (since > period_max_q) period_max_d = since;
				if (frame_s1.armed && over_thr) long_gap_cnt_d = sat_c(long_gap_cnt_q, CNT_ONE);
			end
			if (missing_eff) begin
				recoveries_d   = sat_c(recoveries_q, CNT_ONE);
				recovery_sum_d = sat_t(recovery_sum_q, since);
				rec            = 1'b1;
			end
			missing_d      = 1'b0;
			last_seen_d    = ts;
			seen_d         = 1'b1;
			total_frames_d = sat_c(total_frames_q, CNT_ONE);
			if (frame_s1.armed) armed_frames_d = sat_c(armed_frames_q, CNT_ONE);
		end else begin
			missing_d = missing_eff;
			if (frame_s1.frame_id == status_id_q && frame_s1.length_code == pfgm_pkg::LEN_FULL
				&& phase_hit) begin
				phase_d = 1'b1;
			end
		end

		// result beat from the updated state
		res_d.silence_event   = sil;
		res_d.recovery_event  = rec;
		res_d.event_gap_us    = (sil || rec) ? port_t(since) : '0;
		res_d.armed_frames    = port_c(armed_frames_d);
		res_d.silence_count   = port_c(silence_d);
		res_d.recoveries_out  = port_c(recoveries_d);
		res_d.longest_gap_out = port_t(longest_gap_d);
		res_d.period_min_out  = port_t(period_min_d);
		res_d.period_max_out  = port_t(period_max_d);
		res_d.period_sum_out  = port_t(period_sum_d);
		res_d.closed_runs     = port_c(run_total_d);
		res_d.run_time_total  = port_t(run_time_sum_d);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q             <= 1'b0;
			missing_q          <= 1'b0;
			phase_q            <= 1'b0;
			run_active_q       <= 1'b0;
			last_seen_q        <= '0;
			period_sum_q       <= '0;
			period_min_q       <= '1;
			period_max_q       <= '0;
			longest_gap_q      <= '0;
			recovery_sum_q     <= '0;
			first_sil_q        <= '0;
			run_start_time_q   <= '0;
			run_last_time_q    <= '0;
			run_time_sum_q     <= '0;
			period_samples_q   <= '0;
			long_gap_cnt_q     <= '0;
			recoveries_q       <= '0;
			total_frames_q     <= '0;
			armed_frames_q     <= '0;
			silence_q          <= '0;
			run_start_frames_q <= '0;
			run_last_frames_q  <= '0;
			run_frame_sum_q    <= '0;
			run_total_q        <= '0;
		end else if (advance) begin
			seen_q             <= seen_d;
			missing_q          <= missing_d;
			phase_q            <= phase_d;
			run_active_q       <= run_active_d;
			last_seen_q        <= last_seen_d;
			period_sum_q       <= period_sum_d;
			period_min_q       <= period_min_d;
			period_max_q       <= period_max_d;
			longest_gap_q      <= longest_gap_d;
			recovery_sum_q     <= recovery_sum_d;
			first_sil_q        <= first_sil_d;
			run_start_time_q   <= run_start_time_d;
			run_last_time_q    <= run_last_time_d;
			run_time_sum_q     <= run_time_sum_d;
			period_samples_q   <= period_samples_d;
			long_gap_cnt_q     <= long_gap_cnt_d;
			recoveries_q       <= recoveries_d;
			total_frames_q     <= total_frames_d;
			armed_frames_q     <= armed_frames_d;
			silence_q          <= silence_d;
			run_start_frames_q <= run_start_frames_d;
			run_last_frames_q  <= run_last_frames_d;
			run_frame_sum_q    <= run_frame_sum_d;
			run_total_q        <= run_total_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_d;
	end

	assign results.valid           = valid_s2;
	assign results.silence_event   = res_s2.silence_event;
	assign results.recovery_event  = res_s2.recovery_event;
	assign results.event_gap_us    = res_s2.event_gap_us;
	assign results.armed_frames    = res_s2.armed_frames;
	assign results.silence_count   = res_s2.silence_count;
	assign results.recoveries_out  = res_s2.recoveries_out;
	assign results.longest_gap_out = res_s2.longest_gap_out;
	assign results.period_min_out  = res_s2.period_min_out;
	assign results.period_max_out  = res_s2.period_max_out;
	assign results.period_sum_out  = res_s2.period_sum_out;
	assign results.closed_runs     = res_s2.closed_runs;
	assign results.run_time_total  = res_s2.run_time_total;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the periodic frame gap monitor: a directed table, then random phases.
// Each accepted frame beat is predicted in-bench and checked in order against the result beats.
// Depends on pfgm_pkg, the channel interfaces and periodic_frame_gap_monitor_top.
module tb_top;

	localparam int STALL_LIMIT   = 5000;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 5;
	localparam int PHASE_FRAMES  = 250;
	localparam logic [pfgm_pkg::IDX_W-1:0] REG_UNUSED = 4'd15;

	typedef struct {
		bit                         is_write;
		logic [pfgm_pkg::IDX_W-1:0] idx;
		logic [pfgm_pkg::CFG_W-1:0] data;
		pfgm_pkg::frame_t           frame;
		bit                         typed;
		pfgm_pkg::result_t          expected;
	} step_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_wen;
	logic [pfgm_pkg::IDX_W-1:0] cfg_index;
	logic [pfgm_pkg::CFG_W-1:0] cfg_data;

	pfgm_frame_if  frames_ch();
	pfgm_result_if results_ch();

	periodic_frame_gap_monitor_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.frames   (frames_ch),
		.results  (results_ch)
	);

	always #5 clk = ~clk;

	// Shadow copy of the register file
	logic [pfgm_pkg::ID_W-1:0]  cfg_watched, cfg_status;
	logic [pfgm_pkg::CFG_W-1:0] cfg_gap_thr, cfg_run_gap;

	// Shadow copy of the monitor state
	logic                       have_watched, gap_open, phase_set, run_open;
	logic [pfgm_pkg::TS_W-1:0]  last_watched_ts, sum_of_periods, shortest_period;
	logic [pfgm_pkg::TS_W-1:0]  longest_period;
	logic [pfgm_pkg::TS_W-1:0]  longest_absence, recovery_time_sum, first_silence_ts;
	logic [pfgm_pkg::TS_W-1:0]  run_begin_ts, run_end_ts, run_duration_sum;
	logic [pfgm_pkg::CNT_W-1:0] period_count, overdue_count, recovery_total, frame_total;
	logic [pfgm_pkg::CNT_W-1:0] armed_frame_total, silence_total;
	logic [pfgm_pkg::CNT_W-1:0] run_begin_frames, run_end_frames, run_frames_sum;
	logic [pfgm_pkg::CNT_W-1:0] closed_run_count;

	pfgm_pkg::result_t expected_results[$];
	step_row_t         directed_rows[$];
	int                mismatches = 0;
	int                quiet_cycles = 0;
	bit                sender_idle_on = 1'b1;
	bit                sink_idle_on = 1'b1;
	logic [pfgm_pkg::TS_W-1:0] stream_us;
	int unsigned       period_us, run_span;

	function automatic logic [pfgm_pkg::TS_W-1:0] sat_time(input logic [pfgm_pkg::TS_W-1:0] a,
		input logic [pfgm_pkg::TS_W-1:0] b);
		logic [pfgm_pkg::TS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[pfgm_pkg::TS_W] ? {pfgm_pkg::TS_W{1'b1}} : s[pfgm_pkg::TS_W-1:0];
	endfunction

	function automatic logic [pfgm_pkg::CNT_W-1:0] sat_count(
		input logic [pfgm_pkg::CNT_W-1:0] a, input logic [pfgm_pkg::CNT_W-1:0] b);
		logic [pfgm_pkg::CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[pfgm_pkg::CNT_W] ? {pfgm_pkg::CNT_W{1'b1}} : s[pfgm_pkg::CNT_W-1:0];
	endfunction

	task automatic reset_model();
		cfg_watched = pfgm_pkg::WATCHED_ID_RST;
		cfg_status  = pfgm_pkg::STATUS_ID_RST;
		cfg_gap_thr = pfgm_pkg::GAP_THR_RST;
		cfg_run_gap = pfgm_pkg::RUN_GAP_RST;
		have_watched = 1'b0; gap_open = 1'b0; phase_set = 1'b0; run_open = 1'b0;
		last_watched_ts = '0; sum_of_periods = '0; longest_period = '0;
		shortest_period = '1;
		longest_absence = '0; recovery_time_sum = '0; first_silence_ts = '0;
		run_begin_ts = '0; run_end_ts = '0; run_duration_sum = '0;
		period_count = '0; overdue_count = '0; recovery_total = '0; frame_total = '0;
		armed_frame_total = '0; silence_total = '0;
		run_begin_frames = '0; run_end_frames = '0; run_frames_sum = '0; closed_run_count = '0;
	endtask

	// Work out the result beat of one frame and advance the shadow state
	task automatic predict_monitor(input pfgm_pkg::frame_t f, output pfgm_pkg::result_t r);
		logic [pfgm_pkg::TS_W-1:0] since, delta, spacing;
		r = '0;
		// overdue check, done on every frame
		if (f.armed && have_watched && !gap_open) begin
			since = f.timestamp_us - last_watched_ts;
			if (since > cfg_gap_thr) begin
				gap_open = 1'b1;
				if (silence_total == '0) first_silence_ts = f.timestamp_us;
				silence_total = sat_count(silence_total, 1);
				if (since > longest_absence) longest_absence = since;
				r.silence_event = 1'b1;
				r.event_gap_us  = since;
				if (phase_set) begin
					// wide spacing ends the open run before a new one starts
					spacing = f.timestamp_us - run_end_ts;
					if (run_open && spacing > cfg_run_gap) begin
						run_duration_sum = sat_time(run_duration_sum, run_end_ts - run_begin_ts);
						run_frames_sum = sat_count(run_frames_sum,
							run_end_frames - run_begin_frames);
						closed_run_count = sat_count(closed_run_count, 1);
						run_open = 1'b0;
					end
					if (!run_open) begin
						run_open = 1'b1;
						run_begin_ts = f.timestamp_us;
						run_begin_frames = armed_frame_total;
					end
					run_end_ts = f.timestamp_us;
					run_end_frames = armed_frame_total;
				end
			end
		end
		// watched frame wins over the status frame when both ids match
		if (f.frame_id == cfg_watched) begin
			delta = f.timestamp_us - last_watched_ts;
			if (have_watched) begin
				sum_of_periods = sat_time(sum_of_periods, delta);
				period_count = sat_count(period_count, 1);
				if (delta < shortest_period) shortest_period = delta;
				if (delta > longest_period) longest_period = delta;
				if (f.armed && delta > cfg_gap_thr) begin
					overdue_count = sat_count(overdue_count, 1);
					if (delta > longest_absence) longest_absence = delta;
				end
			end
			if (gap_open) begin
				recovery_total = sat_count(recovery_total, 1);
				recovery_time_sum = sat_time(recovery_time_sum, delta);
				gap_open = 1'b0;
				r.recovery_event = 1'b1;
				r.event_gap_us = delta;
			end
			last_watched_ts = f.timestamp_us;
			have_watched = 1'b1;
			frame_total = sat_count(frame_total, 1);
			if (f.armed) armed_frame_total = sat_count(armed_frame_total, 1);
		end else if (f.frame_id == cfg_status && f.length_code == pfgm_pkg::LEN_FULL) begin
			if (f.payload[39:32] == pfgm_pkg::PHASE_CODE_LO ||
				f.payload[39:32] == pfgm_pkg::PHASE_CODE_HI ||
				f.payload[55:40] != '0 || f.payload[63:56] != '0)
				phase_set = 1'b1;
		end
		r.armed_frames    = armed_frame_total;
		r.silence_count   = silence_total;
		r.recoveries_out  = recovery_total;
		r.longest_gap_out = longest_absence;
		r.period_min_out  = shortest_period;
		r.period_max_out  = longest_period;
		r.period_sum_out  = sum_of_periods;
		r.closed_runs     = closed_run_count;
		r.run_time_total  = run_duration_sum;
	endtask

	function automatic pfgm_pkg::frame_t mk_frame(input logic [pfgm_pkg::TS_W-1:0] ts,
		input logic [pfgm_pkg::ID_W-1:0] id, input logic [pfgm_pkg::LEN_W-1:0] len,
		input logic [pfgm_pkg::PAY_W-1:0] pay, input logic armed);
		pfgm_pkg::frame_t f;
		f.timestamp_us = ts;
		f.frame_id     = id;
		f.length_code  = len;
		f.payload      = pay;
		f.armed        = armed;
		return f;
	endfunction

	// Result with no event, no silence and no runs yet
	function automatic pfgm_pkg::result_t quiet_result(
		input logic [pfgm_pkg::CNT_W-1:0] armed_frames, input logic [pfgm_pkg::TS_W-1:0] pmin,
		input logic [pfgm_pkg::TS_W-1:0] pmax, input logic [pfgm_pkg::TS_W-1:0] psum);
		pfgm_pkg::result_t r;
		r = '0;
		r.armed_frames   = armed_frames;
		r.period_min_out = pmin;
		r.period_max_out = pmax;
		r.period_sum_out = psum;
		return r;
	endfunction

	task automatic push_row(input bit is_write, input logic [pfgm_pkg::IDX_W-1:0] idx,
		input logic [pfgm_pkg::CFG_W-1:0] data, input pfgm_pkg::frame_t f, input bit typed,
		input pfgm_pkg::result_t exp);
		step_row_t row;
		row.is_write = is_write;
		row.idx      = idx;
		row.data     = data;
		row.frame    = f;
		row.typed    = typed;
		row.expected = exp;
		directed_rows.push_back(row);
	endtask

	task automatic row_frame(input pfgm_pkg::frame_t f);
		push_row(1'b0, '0, '0, f, 1'b0, '0);
	endtask

	task automatic row_write(input logic [pfgm_pkg::IDX_W-1:0] idx,
		input logic [pfgm_pkg::CFG_W-1:0] data);
		push_row(1'b1, idx, data, '0, 1'b0, '0);
	endtask

	// Directed table: extremes, status decoding, runs, shared id, threshold extremes
	task automatic build_directed();
		logic [pfgm_pkg::PAY_W-1:0] set_pay;
		logic [pfgm_pkg::ID_W-1:0]  wid, sid;
		logic [pfgm_pkg::LEN_W-1:0] lfull;
		wid   = pfgm_pkg::WATCHED_ID_RST;
		sid   = pfgm_pkg::STATUS_ID_RST;
		lfull = pfgm_pkg::LEN_FULL;
		// any one of the conditions that raise the phase flag
		case ($urandom_range(3, 0))
			0: set_pay = 64'(pfgm_pkg::PHASE_CODE_LO) << 32;
			1: set_pay = 64'(pfgm_pkg::PHASE_CODE_HI) << 32;
			2: set_pay = 64'($urandom_range(16'hFFFF, 1)) << 40;
			default: set_pay = 64'($urandom_range(255, 1)) << 56;
		endcase
		set_pay = set_pay | 64'($urandom);

		push_row(1'b0, '0, '0, mk_frame(48'd0, 11'h000, 4'd0, 64'd0, 1'b0), 1'b1,
			quiet_result(32'd0, '1, '0, '0));
		push_row(1'b0, '0, '0, mk_frame(48'd1000, wid, lfull, 64'd0, 1'b1),
			1'b1, quiet_result(32'd1, '1, '0, '0));
		push_row(1'b0, '0, '0, mk_frame(48'd11000, wid, lfull, 64'd0, 1'b1),
			1'b1, quiet_result(32'd2, 48'd10000, 48'd10000, 48'd10000));
		// overdue, then recovery with an over-threshold period
		row_frame(mk_frame(48'd70000, 11'h7FF, 4'd15, '1, 1'b1));
		row_frame(mk_frame(48'd80000, wid, 4'd0, 64'd0, 1'b1));
		// status frames that leave the phase flag clear
		row_frame(mk_frame(48'd81000, sid, lfull, 64'h0000_0001_FFFF_FFFF, 1'b1));
		row_frame(mk_frame(48'd82000, sid, 4'd7, '1, 1'b1));
		row_frame(mk_frame(48'd83000, sid, 4'd15, '1, 1'b1));
		// disarmed frame sees no gap; armed one latches a window before the phase is set
		row_frame(mk_frame(48'd200000, 11'h000, 4'd0, 64'd0, 1'b0));
		row_frame(mk_frame(48'd200001, 11'h000, lfull, 64'h0000_0004_0000_0000, 1'b1));
		row_frame(mk_frame(48'd200002, sid, lfull, set_pay, 1'b1));
		row_frame(mk_frame(48'd210000, wid, lfull, 64'd0, 1'b1));
		// run opens, extends, then a wide spacing closes it
		row_frame(mk_frame(48'd300000, 11'h7FF, lfull, 64'd0, 1'b1));
		row_frame(mk_frame(48'd300500, wid, lfull, 64'd0, 1'b1));
		row_frame(mk_frame(48'd400000, 11'h7FF, lfull, 64'd0, 1'b1));
		row_frame(mk_frame(48'd400100, wid, lfull, 64'd0, 1'b1));
		row_frame(mk_frame(48'd2000000, 11'h7FF, lfull, 64'd0, 1'b1));
		// timestamp running backwards wraps the period
		row_frame(mk_frame(48'd1000, wid, lfull, 64'd0, 1'b1));
		// watched id set to the status id; upper data bits are dropped
		row_write(pfgm_pkg::REG_WATCHED_ID, 48'hFFFF_FFFF_FE01);
		row_frame(mk_frame(48'd5000, sid, lfull, set_pay, 1'b1));
		// zero thresholds
		row_write(pfgm_pkg::REG_GAP_THR, '0);
		row_write(pfgm_pkg::REG_RUN_GAP, '0);
		row_write(REG_UNUSED, pfgm_pkg::CFG_W'({$urandom, $urandom}));
		row_frame(mk_frame(48'd5001, 11'h7FF, lfull, 64'd0, 1'b1));
		row_frame(mk_frame(48'd5002, 11'h7FF, lfull, 64'd0, 1'b1));
		row_frame(mk_frame('1, sid, lfull, 64'd0, 1'b1));
		// full-scale thresholds
		row_write(pfgm_pkg::REG_GAP_THR, '1);
		row_write(pfgm_pkg::REG_RUN_GAP, '1);
		row_frame(mk_frame(48'd0, 11'h000, 4'd0, 64'd0, 1'b1));
		row_frame(mk_frame(48'h8000_0000_0000, sid, lfull, '1, 1'b1));
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 65) return 0;
		if (roll < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic write_reg(input logic [pfgm_pkg::IDX_W-1:0] idx,
		input logic [pfgm_pkg::CFG_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			pfgm_pkg::REG_WATCHED_ID: cfg_watched = data[pfgm_pkg::ID_W-1:0];
			pfgm_pkg::REG_STATUS_ID:  cfg_status  = data[pfgm_pkg::ID_W-1:0];
			pfgm_pkg::REG_GAP_THR:    cfg_gap_thr = data;
			pfgm_pkg::REG_RUN_GAP:    cfg_run_gap = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result beat has come back
	task automatic drain();
		frames_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_frame(input pfgm_pkg::frame_t f, input bit typed,
		input pfgm_pkg::result_t typed_result);
		pfgm_pkg::result_t predicted;
		frames_ch.valid        <= 1'b1;
		frames_ch.timestamp_us <= f.timestamp_us;
		frames_ch.frame_id     <= f.frame_id;
		frames_ch.length_code  <= f.length_code;
		frames_ch.payload      <= f.payload;
		frames_ch.armed        <= f.armed;
		do @(posedge clk); while (frames_ch.ready !== 1'b1);
		predict_monitor(f, predicted);
		expected_results.push_back(typed ? typed_result : predicted);
		@(negedge clk);
	endtask

	task automatic idle_sender();
		int unsigned gap;
		gap = sender_idle_on ? pick_gap() : 0;
		if (gap != 0) begin
			frames_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Mostly a periodic stream with jitter, some long absences, status frames and noise
	task automatic make_random_frame(output pfgm_pkg::frame_t f);
		int unsigned pick;
		pick = $urandom_range(99, 0);
		f.frame_id    = pfgm_pkg::ID_W'($urandom);
		f.length_code = pfgm_pkg::LEN_W'($urandom_range(8, 0));
		f.payload     = {$urandom, $urandom};
		f.armed       = ($urandom_range(9, 0) != 0);
		if (pick < 55) begin
			stream_us = stream_us
				+ pfgm_pkg::TS_W'(period_us / 2 + $urandom_range(period_us, 0));
			f.frame_id = cfg_watched;
		end else if (pick < 75) begin
			stream_us = stream_us + pfgm_pkg::TS_W'($urandom_range(period_us / 4, 0));
		end else if (pick < 85) begin
			// absence past the threshold, spacing either side of the run gap
			stream_us = stream_us + cfg_gap_thr
				+ pfgm_pkg::TS_W'(1 + $urandom_range(run_span, 0));
			if ($urandom_range(2, 0) == 0) f.frame_id = cfg_watched;
		end else if (pick < 93) begin
			f.frame_id = cfg_status;
			if ($urandom_range(3, 0) == 0) f.length_code = pfgm_pkg::LEN_W'($urandom);
			else f.length_code = pfgm_pkg::LEN_FULL;
		end else begin
			stream_us     = pfgm_pkg::TS_W'({$urandom, $urandom});
			f.length_code = pfgm_pkg::LEN_W'($urandom);
			f.armed       = 1'($urandom_range(1, 0));
		end
		f.timestamp_us = stream_us;
	endtask

	// Result beat checking against the oldest prediction
	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		pfgm_pkg::result_t want;
		if (arst_n && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no frame outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("silence_event", 64'(want.silence_event),
					64'(results_ch.silence_event));
				check_field("recovery_event", 64'(want.recovery_event),
					64'(results_ch.recovery_event));
				check_field("event_gap_us", 64'(want.event_gap_us),
					64'(results_ch.event_gap_us));
				check_field("armed_frames", 64'(want.armed_frames),
					64'(results_ch.armed_frames));
				check_field("silence_count", 64'(want.silence_count),
					64'(results_ch.silence_count));
				check_field("recoveries_out", 64'(want.recoveries_out),
					64'(results_ch.recoveries_out));
				check_field("longest_gap_out", 64'(want.longest_gap_out),
					64'(results_ch.longest_gap_out));
				check_field("period_min_out", 64'(want.period_min_out),
					64'(results_ch.period_min_out));
				check_field("period_max_out", 64'(want.period_max_out),
					64'(results_ch.period_max_out));
				check_field("period_sum_out", 64'(want.period_sum_out),
					64'(results_ch.period_sum_out));
				check_field("closed_runs", 64'(want.closed_runs),
					64'(results_ch.closed_runs));
				check_field("run_time_total", 64'(want.run_time_total),
					64'(results_ch.run_time_total));
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((frames_ch.valid === 1'b1 && frames_ch.ready === 1'b1) ||
			(results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else if (quiet_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Result sink back-pressure
	initial begin : sink_pacing
		int unsigned stall;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = sink_idle_on ? pick_gap() : 0;
			if (stall == 0)
				results_ch.ready <= 1'b1;
			else begin
				results_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		pfgm_pkg::frame_t f;
		int unsigned      thr;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		frames_ch.valid        = 1'b0;
		frames_ch.timestamp_us = '0;
		frames_ch.frame_id     = '0;
		frames_ch.length_code  = '0;
		frames_ch.payload      = '0;
		frames_ch.armed        = 1'b0;
		reset_model();
		build_directed();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				drain();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_frame(directed_rows[i].frame, directed_rows[i].typed,
					directed_rows[i].expected);
				idle_sender();
			end
		end

		stream_us = 48'd10_000_000;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			// one phase runs flat out on both sides
			sender_idle_on = (p != 2);
			sink_idle_on   = (p != 2);
			thr = $urandom_range(200000, 1000);
			write_reg(pfgm_pkg::REG_WATCHED_ID, pfgm_pkg::CFG_W'({$urandom, $urandom}));
			write_reg(pfgm_pkg::REG_STATUS_ID, (p == 3) ? pfgm_pkg::CFG_W'(cfg_watched)
				: pfgm_pkg::CFG_W'({$urandom, $urandom}));
			write_reg(pfgm_pkg::REG_GAP_THR, pfgm_pkg::CFG_W'(thr));
			write_reg(pfgm_pkg::REG_RUN_GAP, pfgm_pkg::CFG_W'($urandom_range(1500000, thr)));
			period_us = thr / 4 + 1;
			run_span  = cfg_run_gap[31:0] * 2;
			for (int n = 0; n < PHASE_FRAMES; n++) begin
				if ((p == 0 && n == 100) || $urandom_range(199, 0) == 0) drain();
				make_random_frame(f);
				send_frame(f, 1'b0, '0);
				idle_sender();
			end
		end

		drain();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d result beats never arrived", expected_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
